FILE: rtl/nhrl_pkg.sv
package nhrl_pkg;

    // table sizes
    localparam int NEIGHBOUR_SLOTS = 16;
    localparam int STATIC_ENTRIES  = 16;
    localparam int DYNAMIC_ENTRIES = 16;

    // index and count widths follow from the table sizes
    localparam int NBR_IDX_W = (NEIGHBOUR_SLOTS > 1) ? $clog2(NEIGHBOUR_SLOTS) : 1;
    localparam int ST_IDX_W  = (STATIC_ENTRIES > 1) ? $clog2(STATIC_ENTRIES) : 1;
    localparam int DYN_IDX_W = (DYNAMIC_ENTRIES > 1) ? $clog2(DYNAMIC_ENTRIES) : 1;
    localparam int NBR_CNT_W = $clog2(NEIGHBOUR_SLOTS + 1);

    // field widths
    localparam int OPCODE_W = 2;
    localparam int UNIT_W   = 8;
    localparam int RSSI_W   = 16;
    localparam int TIME_W   = 32;
    localparam int ENTRY_W  = 4;
    localparam int STATUS_W = 4;
    localparam int SLOT_W   = 4;
    localparam int FULL_W   = 5;
    localparam int FULL_MAX = 31;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_UNIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_UNIT = 1'b1;

    localparam logic [UNIT_W-1:0] OWN_UNIT_RESET = 8'd0;
    localparam logic [UNIT_W-1:0] MAX_UNIT_RESET = 8'd255;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_ROUTE    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_UPDATE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD_ST  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_LOAD_DYN = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_INVALID   = 4'd0;
    localparam logic [STATUS_W-1:0] STS_NEIGHBOUR = 4'd1;
    localparam logic [STATUS_W-1:0] STS_STATIC    = 4'd2;
    localparam logic [STATUS_W-1:0] STS_DYNAMIC   = 4'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 4'd4;
    localparam logic [STATUS_W-1:0] STS_REFRESHED = 4'd5;
    localparam logic [STATUS_W-1:0] STS_INSERTED  = 4'd6;
    localparam logic [STATUS_W-1:0] STS_FULL      = 4'd7;
    localparam logic [STATUS_W-1:0] STS_LOADED    = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/nhrl_ctrl.sv
module nhrl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  nhrl_pkg::dp_status_t dp_status,
    output nhrl_pkg::ctrl_cmd_t  cmd
);
    import nhrl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_RESOLVE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        cmd.capture = in_valid && (state_reg == ST_IDLE);
        cmd.commit  = (state_reg == ST_RESOLVE) && dp_status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (dp_status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/nhrl_datapath.sv
module nhrl_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nhrl_pkg::ctrl_cmd_t                 cmd,
    output nhrl_pkg::dp_status_t                dp_status,
    input  logic                                cfg_we,
    input  logic [nhrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nhrl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [nhrl_pkg::OPCODE_W-1:0]       opcode,
    input  logic [nhrl_pkg::UNIT_W-1:0]         unit_id,
    input  logic signed [nhrl_pkg::RSSI_W-1:0]  link_rssi,
    input  logic [nhrl_pkg::TIME_W-1:0]         time_stamp,
    input  logic [nhrl_pkg::ENTRY_W-1:0]        entry_index,
    input  logic [nhrl_pkg::UNIT_W-1:0]         hop_unit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [nhrl_pkg::STATUS_W-1:0]       status,
    output logic                                header_routed,
    output logic [nhrl_pkg::UNIT_W-1:0]         source_unit,
    output logic [nhrl_pkg::UNIT_W-1:0]         dest_unit,
    output logic [nhrl_pkg::UNIT_W-1:0]         next_hop,
    output logic [nhrl_pkg::SLOT_W-1:0]         slot_used,
    output logic [nhrl_pkg::FULL_W-1:0]         full_slot_count
);
    import nhrl_pkg::*;

    // configuration
    logic [UNIT_W-1:0] own_unit_reg;
    logic [UNIT_W-1:0] max_unit_reg;

    // tables
    logic [UNIT_W-1:0]        nbr_unit      [NEIGHBOUR_SLOTS];
    logic signed [RSSI_W-1:0] nbr_rssi      [NEIGHBOUR_SLOTS];
    logic [TIME_W-1:0]        nbr_last_seen [NEIGHBOUR_SLOTS];
    logic [NEIGHBOUR_SLOTS-1:0] nbr_valid_reg;
    logic [UNIT_W-1:0]        static_dest   [STATIC_ENTRIES];
    logic [UNIT_W-1:0]        static_next   [STATIC_ENTRIES];
    logic [STATIC_ENTRIES-1:0] static_valid_reg;
    logic [UNIT_W-1:0]        dyn_dest      [DYNAMIC_ENTRIES];
    logic [UNIT_W-1:0]        dyn_next      [DYNAMIC_ENTRIES];
    logic [DYNAMIC_ENTRIES-1:0] dyn_valid_reg;
    logic [NBR_CNT_W-1:0]     nbr_cnt_reg;
    logic [NBR_CNT_W-1:0]     nbr_cnt_next;

    // captured word and match vectors
    logic [OPCODE_W-1:0]      op_reg;
    logic [UNIT_W-1:0]        unit_reg;
    logic signed [RSSI_W-1:0] rssi_reg;
    logic [TIME_W-1:0]        time_reg;
    logic [ENTRY_W-1:0]       idx_reg;
    logic [UNIT_W-1:0]        hop_reg;
    logic [NEIGHBOUR_SLOTS-1:0] nbr_hit_reg;
    logic [STATIC_ENTRIES-1:0]  st_hit_reg;
    logic [DYNAMIC_ENTRIES-1:0] dyn_hit_reg;

    // first-match encoders
    logic                 nbr_any;
    logic [NBR_IDX_W-1:0] nbr_idx;
    logic                 free_any;
    logic [NBR_IDX_W-1:0] free_idx;
    logic                 st_any;
    logic [ST_IDX_W-1:0]  st_idx;
    logic                 dyn_any;
    logic [DYN_IDX_W-1:0] dyn_idx;
    logic [UNIT_W-1:0]    st_hop;

    // resolve results
    logic                 nbr_we;
    logic [NBR_IDX_W-1:0] nbr_wr_idx;
    logic                 nbr_insert;
    logic                 st_we;
    logic                 dyn_we;
    logic [STATUS_W-1:0]  status_next;
    logic                 routed_next;
    logic [UNIT_W-1:0]    source_next;
    logic [UNIT_W-1:0]    dest_next;
    logic [UNIT_W-1:0]    hop_next;
    logic [SLOT_W-1:0]    slot_next;
    logic [FULL_W-1:0]    full_next;

    // output register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 routed_reg;
    logic [UNIT_W-1:0]    source_reg;
    logic [UNIT_W-1:0]    dest_reg;
    logic [UNIT_W-1:0]    hop_out_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [FULL_W-1:0]    full_reg;

    assign dp_status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_unit_reg <= OWN_UNIT_RESET;
            max_unit_reg <= MAX_UNIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_UNIT: own_unit_reg <= cfg_data;
                CFG_MAX_UNIT: max_unit_reg <= cfg_data;
                default:      own_unit_reg <= own_unit_reg;
            endcase
        end
    end

    // compares against the live port at acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            unit_reg <= unit_id;
            rssi_reg <= link_rssi;
            time_reg <= time_stamp;
            idx_reg  <= entry_index;
            hop_reg  <= hop_unit;
            for (int i = 0; i < NEIGHBOUR_SLOTS; i++)
            begin
                nbr_hit_reg[i] <= nbr_valid_reg[i] && (nbr_unit[i] == unit_id);
            end
            for (int i = 0; i < STATIC_ENTRIES; i++)
            begin
                st_hit_reg[i] <= static_valid_reg[i] && (static_dest[i] == unit_id);
            end
            for (int i = 0; i < DYNAMIC_ENTRIES; i++)
            begin
                dyn_hit_reg[i] <= dyn_valid_reg[i] && (dyn_dest[i] == unit_id);
            end
        end
    end

    // lowest index wins
    always_comb
    begin
        nbr_any  = |nbr_hit_reg;
        free_any = ~&nbr_valid_reg;
        st_any   = |st_hit_reg;
        dyn_any  = |dyn_hit_reg;
        nbr_idx  = '0;
        free_idx = '0;
        st_idx   = '0;
        dyn_idx  = '0;
        for (int i = NEIGHBOUR_SLOTS - 1; i >= 0; i--)
        begin
            if (nbr_hit_reg[i])
            begin
                nbr_idx = NBR_IDX_W'(i);
            end
            if (!nbr_valid_reg[i])
            begin
                free_idx = NBR_IDX_W'(i);
            end
        end
        for (int i = STATIC_ENTRIES - 1; i >= 0; i--)
        begin
            if (st_hit_reg[i])
            begin
                st_idx = ST_IDX_W'(i);
            end
        end
        for (int i = DYNAMIC_ENTRIES - 1; i >= 0; i--)
        begin
            if (dyn_hit_reg[i])
            begin
                dyn_idx = DYN_IDX_W'(i);
            end
        end
    end

    assign st_hop = static_next[st_idx];

    always_comb
    begin
        nbr_we      = 1'b0;
        nbr_wr_idx  = nbr_idx;
        nbr_insert  = 1'b0;
        st_we       = 1'b0;
        dyn_we      = 1'b0;
        status_next = STS_INVALID;
        routed_next = 1'b0;
        source_next = '0;
        dest_next   = '0;
        hop_next    = '0;
        slot_next   = '0;
        unique case (op_reg)
            OP_ROUTE:
            begin
                if (unit_reg <= max_unit_reg)
                begin
                    source_next = own_unit_reg;
                    dest_next   = unit_reg;
                    hop_next    = unit_reg;
                    if (nbr_any)
                    begin
                        status_next = STS_NEIGHBOUR;
                    end
                    else if (st_any)
                    begin
                        status_next = STS_STATIC;
                        if (st_hop != unit_reg)
                        begin
                            routed_next = 1'b1;
                            hop_next    = st_hop;
                        end
                    end
                    else if (dyn_any)
                    begin
                        status_next = STS_DYNAMIC;
                        routed_next = 1'b1;
                        hop_next    = dyn_next[dyn_idx];
                    end
                    else
                    begin
                        status_next = STS_NOT_FOUND;
                    end
                end
            end
            OP_UPDATE:
            begin
                if (nbr_any)
                begin
                    nbr_we      = 1'b1;
                    status_next = STS_REFRESHED;
                    slot_next   = SLOT_W'(nbr_idx);
                end
                else if (free_any)
                begin
                    nbr_we      = 1'b1;
                    nbr_insert  = 1'b1;
                    nbr_wr_idx  = free_idx;
                    status_next = STS_INSERTED;
                    slot_next   = SLOT_W'(free_idx);
                end
                else
                begin
                    status_next = STS_FULL;
                end
            end
            OP_LOAD_ST:
            begin
                if (32'(idx_reg) < STATIC_ENTRIES)
                begin
                    st_we       = 1'b1;
                    status_next = STS_LOADED;
                end
            end
            OP_LOAD_DYN:
            begin
                if (32'(idx_reg) < DYNAMIC_ENTRIES)
                begin
                    dyn_we      = 1'b1;
                    status_next = STS_LOADED;
                end
            end
            default:
            begin
                status_next = STS_INVALID;
            end
        endcase

        nbr_cnt_next = nbr_cnt_reg + NBR_CNT_W'(nbr_insert);
        if (32'(nbr_cnt_next) > FULL_MAX)
        begin
            full_next = FULL_W'(FULL_MAX);
        end
        else
        begin
            full_next = FULL_W'(nbr_cnt_next);
        end
    end

    // table payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.commit && nbr_we)
        begin
            nbr_unit[nbr_wr_idx]      <= unit_reg;
            nbr_rssi[nbr_wr_idx]      <= rssi_reg;
            nbr_last_seen[nbr_wr_idx] <= time_reg;
        end
        if (cmd.commit && st_we)
        begin
            static_dest[ST_IDX_W'(idx_reg)] <= unit_reg;
            static_next[ST_IDX_W'(idx_reg)] <= hop_reg;
        end
        if (cmd.commit && dyn_we)
        begin
            dyn_dest[DYN_IDX_W'(idx_reg)] <= unit_reg;
            dyn_next[DYN_IDX_W'(idx_reg)] <= hop_reg;
        end
    end

    // valid marks and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbr_valid_reg    <= '0;
            static_valid_reg <= '0;
            dyn_valid_reg    <= '0;
            nbr_cnt_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            if (nbr_we)
            begin
                nbr_valid_reg[nbr_wr_idx] <= 1'b1;
            end
            if (st_we)
            begin
                static_valid_reg[ST_IDX_W'(idx_reg)] <= 1'b1;
            end
            if (dyn_we)
            begin
                dyn_valid_reg[DYN_IDX_W'(idx_reg)] <= 1'b1;
            end
            nbr_cnt_reg <= nbr_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= status_next;
            routed_reg  <= routed_next;
            source_reg  <= source_next;
            dest_reg    <= dest_next;
            hop_out_reg <= hop_next;
            slot_reg    <= slot_next;
            full_reg    <= full_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign header_routed   = routed_reg;
    assign source_unit     = source_reg;
    assign dest_unit       = dest_reg;
    assign next_hop        = hop_out_reg;
    assign slot_used       = slot_reg;
    assign full_slot_count = full_reg;

endmodule

FILE: rtl/next_hop_route_lookup.sv
// channel   direction  handshake              payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// request   in         in_valid / in_ready    opcode, unit_id, link_rssi, time_stamp,
//                                             entry_index, hop_unit
// result    out        out_valid / out_ready  status, header_routed, source_unit, dest_unit,
//                                             next_hop, slot_used, full_slot_count
//
// one word at a time: the table compares are registered at acceptance, the
// first-match encode, table write and result load happen in the resolve state
// reset (rst_n, asynchronous) clears every valid mark and the fill count and
// loads the reset configuration; table payload is not reset
// a result waiting in the output register does not hold off acceptance; the
// resolve cycle waits only while that register is still occupied
module next_hop_route_lookup (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nhrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nhrl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [nhrl_pkg::OPCODE_W-1:0]       opcode,
    input  logic [nhrl_pkg::UNIT_W-1:0]         unit_id,
    input  logic signed [nhrl_pkg::RSSI_W-1:0]  link_rssi,
    input  logic [nhrl_pkg::TIME_W-1:0]         time_stamp,
    input  logic [nhrl_pkg::ENTRY_W-1:0]        entry_index,
    input  logic [nhrl_pkg::UNIT_W-1:0]         hop_unit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [nhrl_pkg::STATUS_W-1:0]       status,
    output logic                                header_routed,
    output logic [nhrl_pkg::UNIT_W-1:0]         source_unit,
    output logic [nhrl_pkg::UNIT_W-1:0]         dest_unit,
    output logic [nhrl_pkg::UNIT_W-1:0]         next_hop,
    output logic [nhrl_pkg::SLOT_W-1:0]         slot_used,
    output logic [nhrl_pkg::FULL_W-1:0]         full_slot_count
);
    import nhrl_pkg::*;

    // command and status between controller and datapath
    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // sequencing: idle / resolve
    nhrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // tables, compares, encoders and the output register
    nhrl_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dp_status       (dp_status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .unit_id         (unit_id),
        .link_rssi       (link_rssi),
        .time_stamp      (time_stamp),
        .entry_index     (entry_index),
        .hop_unit        (hop_unit),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .header_routed   (header_routed),
        .source_unit     (source_unit),
        .dest_unit       (dest_unit),
        .next_hop        (next_hop),
        .slot_used       (slot_used),
        .full_slot_count (full_slot_count)
    );

endmodule

FILE: verif/tb_next_hop_route_lookup.sv
module tb_next_hop_route_lookup;

    import nhrl_pkg::*;

    // one request word as driven on the input channel
    typedef struct packed {
        logic [OPCODE_W-1:0]       op;
        logic [UNIT_W-1:0]         unit;
        logic signed [RSSI_W-1:0]  rssi;
        logic [TIME_W-1:0]         stamp;
        logic [ENTRY_W-1:0]        entry;
        logic [UNIT_W-1:0]         hop;
    } route_word_t;

    // one answer word as seen on the result channel
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 routed;
        logic [UNIT_W-1:0]    source;
        logic [UNIT_W-1:0]    dest;
        logic [UNIT_W-1:0]    hop;
        logic [SLOT_W-1:0]    slot;
        logic [FULL_W-1:0]    fill;
    } route_answer_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [UNIT_W-1:0]          unit_id;
    logic signed [RSSI_W-1:0]   link_rssi;
    logic [TIME_W-1:0]          time_stamp;
    logic [ENTRY_W-1:0]         entry_index;
    logic [UNIT_W-1:0]          hop_unit;
    logic                       out_valid;
    logic                       out_ready;
    logic [STATUS_W-1:0]        status;
    logic                       header_routed;
    logic [UNIT_W-1:0]          source_unit;
    logic [UNIT_W-1:0]          dest_unit;
    logic [UNIT_W-1:0]          next_hop;
    logic [SLOT_W-1:0]          slot_used;
    logic [FULL_W-1:0]          full_slot_count;

    next_hop_route_lookup dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .unit_id         (unit_id),
        .link_rssi       (link_rssi),
        .time_stamp      (time_stamp),
        .entry_index     (entry_index),
        .hop_unit        (hop_unit),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .header_routed   (header_routed),
        .source_unit     (source_unit),
        .dest_unit       (dest_unit),
        .next_hop        (next_hop),
        .slot_used       (slot_used),
        .full_slot_count (full_slot_count)
    );

    // ------------------------------------------------------------------
    // shadow copy of the node: configuration and the three tables
    // valid marks are bit arrays, so they start cleared like after reset
    // ------------------------------------------------------------------
    logic [UNIT_W-1:0]          own_unit = OWN_UNIT_RESET;
    logic [UNIT_W-1:0]          max_unit = MAX_UNIT_RESET;

    logic [UNIT_W-1:0]          peer_unit  [NEIGHBOUR_SLOTS];
    bit                         peer_live  [NEIGHBOUR_SLOTS];
    logic signed [RSSI_W-1:0]   peer_rssi  [NEIGHBOUR_SLOTS];
    logic [TIME_W-1:0]          peer_seen  [NEIGHBOUR_SLOTS];
    logic [UNIT_W-1:0]          fixed_dest [STATIC_ENTRIES];
    logic [UNIT_W-1:0]          fixed_hop  [STATIC_ENTRIES];
    bit                         fixed_live [STATIC_ENTRIES];
    logic [UNIT_W-1:0]          learnt_dest [DYNAMIC_ENTRIES];
    logic [UNIT_W-1:0]          learnt_hop  [DYNAMIC_ENTRIES];
    bit                         learnt_live [DYNAMIC_ENTRIES];

    // answers owed by the block, oldest first
    route_answer_t answers_pending[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int config_count   = 0;
    int status_seen [16];

    // ------------------------------------------------------------------
    // clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // well beyond the slowest legal run of ~1100 words
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // shadow model helpers
    // ------------------------------------------------------------------
    function automatic int live_peer_count();
        int n;
        n = 0;
        for (int i = 0; i < NEIGHBOUR_SLOTS; i++)
            if (peer_live[i])
                n++;
        return n;
    endfunction

    // works out the answer to one accepted word and applies its table writes
    function automatic route_answer_t lookup_and_learn(route_word_t w);
        route_answer_t a;
        int hit;
        int n;
        a = '0;
        hit = -1;
        case (w.op)
            OP_ROUTE:
            begin
                // above the network limit: status invalid, header left at zero
                if (w.unit <= max_unit)
                begin
                    a.status = STS_NOT_FOUND;
                    a.source = own_unit;
                    a.dest   = w.unit;
                    a.hop    = w.unit;
                    // descending scans so the lowest matching index wins
                    for (int i = NEIGHBOUR_SLOTS - 1; i >= 0; i--)
                        if (peer_live[i] && peer_unit[i] == w.unit)
                            hit = i;
                    if (hit >= 0)
                        a.status = STS_NEIGHBOUR;
                    else
                    begin
                        for (int i = STATIC_ENTRIES - 1; i >= 0; i--)
                            if (fixed_live[i] && fixed_dest[i] == w.unit)
                                hit = i;
                        if (hit >= 0)
                        begin
                            a.status = STS_STATIC;
                            // a static hop equal to the destination stays direct
                            if (fixed_hop[hit] != w.unit)
                            begin
                                a.routed = 1'b1;
                                a.hop    = fixed_hop[hit];
                            end
                        end
                        else
                        begin
                            for (int i = DYNAMIC_ENTRIES - 1; i >= 0; i--)
                                if (learnt_live[i] && learnt_dest[i] == w.unit)
                                    hit = i;
                            if (hit >= 0)
                            begin
                                a.status = STS_DYNAMIC;
                                a.routed = 1'b1;
                                a.hop    = learnt_hop[hit];
                            end
                        end
                    end
                end
            end
            OP_UPDATE:
            begin
                for (int i = NEIGHBOUR_SLOTS - 1; i >= 0; i--)
                    if (peer_live[i] && peer_unit[i] == w.unit)
                        hit = i;
                if (hit >= 0)
                    a.status = STS_REFRESHED;
                else
                begin
                    for (int i = NEIGHBOUR_SLOTS - 1; i >= 0; i--)
                        if (!peer_live[i])
                            hit = i;
                    a.status = (hit >= 0) ? STS_INSERTED : STS_FULL;
                end
                if (hit >= 0)
                begin
                    peer_unit[hit] = w.unit;
                    peer_rssi[hit] = w.rssi;
                    peer_seen[hit] = w.stamp;
                    peer_live[hit] = 1'b1;
                    a.slot = SLOT_W'(hit);
                end
            end
            OP_LOAD_ST:
            begin
                if (32'(w.entry) < STATIC_ENTRIES)
                begin
                    fixed_dest[w.entry] = w.unit;
                    fixed_hop[w.entry]  = w.hop;
                    fixed_live[w.entry] = 1'b1;
                    a.status = STS_LOADED;
                end
            end
            default:
            begin
                if (32'(w.entry) < DYNAMIC_ENTRIES)
                begin
                    learnt_dest[w.entry] = w.unit;
                    learnt_hop[w.entry]  = w.hop;
                    learnt_live[w.entry] = 1'b1;
                    a.status = STS_LOADED;
                end
            end
        endcase
        n = live_peer_count();
        a.fill = (n > FULL_MAX) ? FULL_W'(FULL_MAX) : FULL_W'(n);
        return a;
    endfunction

    // ------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // values read here are the ones held just before the edge
    always @(posedge clk)
    begin : check_result
        route_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (answers_pending.size() == 0)
            begin
                $error("result word with nothing outstanding, status %0d", status);
                mismatches++;
            end
            else
            begin
                want = answers_pending.pop_front();
                status_seen[want.status]++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (header_routed !== want.routed)
                begin
                    $error("header_routed: expected %0d, got %0d", want.routed, header_routed);
                    mismatches++;
                end
                if (source_unit !== want.source)
                begin
                    $error("source_unit: expected %0d, got %0d", want.source, source_unit);
                    mismatches++;
                end
                if (dest_unit !== want.dest)
                begin
                    $error("dest_unit: expected %0d, got %0d", want.dest, dest_unit);
                    mismatches++;
                end
                if (next_hop !== want.hop)
                begin
                    $error("next_hop: expected %0d, got %0d", want.hop, next_hop);
                    mismatches++;
                end
                if (slot_used !== want.slot)
                begin
                    $error("slot_used: expected %0d, got %0d", want.slot, slot_used);
                    mismatches++;
                end
                if (full_slot_count !== want.fill)
                begin
                    $error("full_slot_count: expected %0d, got %0d", want.fill,
                           full_slot_count);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // all tasks start and return in the time step of a rising edge
    // ------------------------------------------------------------------

    // valid is only dropped when a gap is taken, so back-to-back words
    // never see a low and a high written in the same step
    task automatic send_word(input route_word_t w);
        bit gapped;
        gapped = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            if (!gapped)
                in_valid <= 1'b0;
            gapped = 1'b1;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= w.op;
        unit_id     <= w.unit;
        link_rssi   <= w.rssi;
        time_stamp  <= w.stamp;
        entry_index <= w.entry;
        hop_unit    <= w.hop;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge: the answer joins the queue in order
        answers_pending.push_back(lookup_and_learn(w));
        words_sent++;
    endtask

    task automatic request(input logic [OPCODE_W-1:0] op, input logic [UNIT_W-1:0] unit,
                           input logic [RSSI_W-1:0] rssi, input logic [TIME_W-1:0] stamp,
                           input logic [ENTRY_W-1:0] entry, input logic [UNIT_W-1:0] hop);
        route_word_t w;
        w.op    = op;
        w.unit  = unit;
        w.rssi  = rssi;
        w.stamp = stamp;
        w.entry = entry;
        w.hop   = hop;
        send_word(w);
    endtask

    // drop valid, wait for every answer, then let the resolve stage settle
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (answers_pending.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (answers_pending.size() > 0)
        begin
            $error("%0d result words never arrived", answers_pending.size());
            mismatches += answers_pending.size();
            answers_pending.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // both registers in consecutive cycles, only while the block is idle
    task automatic set_node_config(input logic [UNIT_W-1:0] own,
                                   input logic [UNIT_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_UNIT;
        cfg_data  <= own;
        @(posedge clk);
        cfg_index <= CFG_MAX_UNIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we   <= 1'b0;
        own_unit = own;
        max_unit = limit;
        config_count++;
    endtask

    // mostly a small pool of units so that tables actually hit,
    // plus the top of the range and the odd fully random unit
    function automatic logic [UNIT_W-1:0] pick_unit();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return UNIT_W'($urandom_range(0, 39));
        else if (r < 78)
            return UNIT_W'(255 - $urandom_range(0, 3));
        else
            return UNIT_W'($urandom_range(0, 255));
    endfunction

    function automatic route_word_t random_word();
        route_word_t w;
        int r;
        r = $urandom_range(99);
        if (r < 45)
            w.op = OP_ROUTE;
        else if (r < 65)
            w.op = OP_UPDATE;
        else if (r < 82)
            w.op = OP_LOAD_ST;
        else
            w.op = OP_LOAD_DYN;
        w.unit  = pick_unit();
        w.rssi  = RSSI_W'($urandom);
        w.stamp = $urandom;
        w.entry = ENTRY_W'($urandom_range(0, 15));
        // a fair share of static entries that point straight at the destination
        w.hop   = ($urandom_range(99) < 30) ? w.unit : pick_unit();
        return w;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // priority order, first-index wins, direct static hop, destination limit
    task automatic test_lookup_priority();
        // empty tables: every lookup misses, both ends of the unit range
        request(OP_ROUTE,    8'd0,   16'sd0, 32'd0, 4'd0,  8'd0);
        request(OP_ROUTE,    8'd255, 16'sd0, 32'd0, 4'd0,  8'd0);
        // static: one direct entry, two routed entries for the same unit
        request(OP_LOAD_ST,  8'd5,   16'sd0, 32'd0, 4'd0,  8'd5);
        request(OP_LOAD_ST,  8'd7,   16'sd0, 32'd0, 4'd15, 8'd9);
        request(OP_LOAD_ST,  8'd7,   16'sd0, 32'd0, 4'd3,  8'd11);
        // dynamic: one shadowed by static, two for unit 9 at different slots
        request(OP_LOAD_DYN, 8'd9,   16'sd0, 32'd0, 4'd15, 8'd3);
        request(OP_LOAD_DYN, 8'd7,   16'sd0, 32'd0, 4'd0,  8'd200);
        request(OP_LOAD_DYN, 8'd9,   16'sd0, 32'd0, 4'd4,  8'd4);
        request(OP_ROUTE,    8'd5,   16'sd0, 32'd0, 4'd0,  8'd0);
        request(OP_ROUTE,    8'd7,   16'sd0, 32'd0, 4'd0,  8'd0);
        request(OP_ROUTE,    8'd9,   16'sd0, 32'd0, 4'd0,  8'd0);
        // neighbour insert then refresh, rssi and time at their extremes
        request(OP_UPDATE,   8'd5,   16'sh8000, 32'h0000_0000, 4'd0, 8'd0);
        request(OP_UPDATE,   8'd5,   16'sh7fff, 32'hffff_ffff, 4'd0, 8'd0);
        request(OP_UPDATE,   8'd255, 16'sd1,    32'h8000_0000, 4'd0, 8'd0);
        // neighbour now outranks the static entry
        request(OP_ROUTE,    8'd5,   16'sd0, 32'd0, 4'd0,  8'd0);
        request(OP_ROUTE,    8'd255, 16'sd0, 32'd0, 4'd0,  8'd0);
        drain_results();

        // tighter network limit, new source unit
        set_node_config(8'd255, 8'd100);
        request(OP_ROUTE,    8'd101, 16'sd0, 32'd0, 4'd0,  8'd0);
        request(OP_ROUTE,    8'd100, 16'sd0, 32'd0, 4'd0,  8'd0);
        // known neighbour beyond the limit is still rejected
        request(OP_ROUTE,    8'd255, 16'sd0, 32'd0, 4'd0,  8'd0);
        request(OP_ROUTE,    8'd7,   16'sd0, 32'd0, 4'd0,  8'd0);
        drain_results();
    endtask

    // random mix in two register settings under one idling profile
    task automatic test_random_traffic(input int send_pct, input int stall_pct, input int words,
                                       input logic [UNIT_W-1:0] own_a,
                                       input logic [UNIT_W-1:0] max_a,
                                       input logic [UNIT_W-1:0] own_b,
                                       input logic [UNIT_W-1:0] max_b);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        set_node_config(own_a, max_a);
        repeat (words / 2)
            send_word(random_word());
        drain_results();
        set_node_config(own_b, max_b);
        repeat (words - words / 2)
            send_word(random_word());
        drain_results();
    endtask

    // fill every neighbour slot, then a stranger gets full, a known one refreshes
    task automatic test_full_table();
        int u;
        bit known;
        set_node_config(8'h3c, 8'd255);
        u = 0;
        while (live_peer_count() < NEIGHBOUR_SLOTS && u < 256)
        begin
            known = 1'b0;
            for (int i = 0; i < NEIGHBOUR_SLOTS; i++)
                if (peer_live[i] && peer_unit[i] == UNIT_W'(u))
                    known = 1'b1;
            if (!known)
                request(OP_UPDATE, UNIT_W'(u), RSSI_W'($urandom), $urandom, 4'd0, 8'd0);
            u++;
        end
        // look for a unit that is not a neighbour
        u = 0;
        known = 1'b1;
        while (known)
        begin
            known = 1'b0;
            for (int i = 0; i < NEIGHBOUR_SLOTS; i++)
                if (peer_live[i] && peer_unit[i] == UNIT_W'(u))
                    known = 1'b1;
            if (known)
                u++;
        end
        request(OP_UPDATE, UNIT_W'(u),    RSSI_W'($urandom), $urandom, 4'd0, 8'd0);
        request(OP_UPDATE, peer_unit[15], RSSI_W'($urandom), $urandom, 4'd0, 8'd0);
        request(OP_ROUTE,  peer_unit[15], 16'sd0,   32'd0,    4'd0, 8'd0);
        request(OP_ROUTE,  UNIT_W'(u),    16'sd0,   32'd0,    4'd0, 8'd0);
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_OWN_UNIT;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        opcode      <= OP_ROUTE;
        unit_id     <= '0;
        link_rssi   <= '0;
        time_stamp  <= '0;
        entry_index <= '0;
        hop_unit    <= '0;
        out_ready   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lookup_priority();
        // sender idles lightly and receiver heavily, then the reverse, then neither
        test_random_traffic(12, 63, 350, 8'd255, 8'd255, 8'd0, 8'd0);
        test_random_traffic(63, 12, 350, UNIT_W'($urandom_range(0, 255)), 8'd200,
                            8'h5a, 8'd30);
        test_random_traffic(0, 0, 350, 8'd1, 8'd254, UNIT_W'($urandom), UNIT_W'($urandom));
        test_full_table();

        $display("covered %0d request words over %0d register settings, %0d results checked",
                 words_sent, config_count, words_checked);
        $display("answers nbr %0d st %0d dyn %0d miss %0d rej %0d ins %0d ref %0d full %0d",
                 status_seen[STS_NEIGHBOUR], status_seen[STS_STATIC],
                 status_seen[STS_DYNAMIC], status_seen[STS_NOT_FOUND],
                 status_seen[STS_INVALID], status_seen[STS_INSERTED],
                 status_seen[STS_REFRESHED], status_seen[STS_FULL]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
